/* design/efsd_pkg.sv */
`timescale 1ns / 1ps

package efsd_pkg;

    // field and load widths
    localparam int LOAD_W          = 32;
    localparam int DUR_W           = 16;
    localparam int SRV_W           = 5;
    localparam int CNT_W           = 5;
    localparam int DEF_MAX_SERVERS = 16;

    // output tdata packing, padded to whole bytes
    localparam int OUT_FIELD_W = 2 * SRV_W + 1;
    localparam int OUT_DATA_W  = ((OUT_FIELD_W + 7) / 8) * 8;

    // request kinds carried on tuser
    localparam logic MODE_ASSIGN = 1'b0;
    localparam logic MODE_CLEAR  = 1'b1;

    typedef logic [LOAD_W-1:0] t_load;

endpackage

/* design/earliest_free_server_dispatch.sv */
`timescale 1ns / 1ps

// Earliest-free server dispatch.
// Input stream (s_axis): one request per beat. tuser selects the kind:
// assign a job (0) or clear all server loads (1); tdata carries the job
// duration. Output stream (m_axis): one result per request, carrying the
// assigned server (0 for a clear), the server the next job would receive
// and a flag set when the assigned server's load reached its maximum.
// Config channel (i_cfg_valid/o_cfg_ready/i_cfg_data): server count,
// always ready; write it only while no request is in flight.
// A request lands in the input register and its result in the result
// register, which loads when the receiver does not stall. Throughput: one
// request per cycle while the receiver takes results, set by the saturating
// add and the comparator tree over the active server loads, which both lie
// between the two registers.
// The least-loaded server is kept in a register so the add needs no search.
// Reset: all loads zero, server count 1, both stages empty.
// When the receiver stalls, the result register holds, the input register
// fills, and s_axis_tready falls until the result is taken.
module earliest_free_server_dispatch
    import efsd_pkg::*;
#(
    parameter int MAX_SERVERS = DEF_MAX_SERVERS
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // config write channel
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CNT_W-1:0]      i_cfg_data,     // server_count
    // request stream
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [DUR_W-1:0]      s_axis_tdata,   // [15:0] job_duration
    input  logic                  s_axis_tuser,   // [0] mode
    // result stream
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    output logic [OUT_DATA_W-1:0] m_axis_tdata    // [4:0] assigned_server,
                                                  // [9:5] next_server,
                                                  // [10] load_saturated
);

    localparam int IW = (MAX_SERVERS > 1) ? $clog2(MAX_SERVERS) : 1;
    localparam int P  = 1 << IW;
    localparam int AW = $clog2(MAX_SERVERS + 1) + 1;

    // state
    logic              r_in_valid;
    logic              r_in_mode;
    logic [DUR_W-1:0]  r_in_dur;
    logic              r_out_valid;
    logic [SRV_W-1:0]  r_out_assigned;
    logic [SRV_W-1:0]  r_out_next;
    logic              r_out_sat;
    logic [CNT_W-1:0]  r_count;
    logic [CNT_W-1:0]  n_count;
    t_load             r_loads [MAX_SERVERS];
    t_load             n_loads [MAX_SERVERS];
    logic [IW-1:0]     r_best;
    logic [IW-1:0]     n_best;

    logic              out_load;
    logic              adv;
    logic [AW-1:0]     n_active;
    t_load             old_load;
    logic [LOAD_W:0]   wide_sum;
    t_load             new_load;
    logic              new_sat;

    // comparator tree nodes, leaves at P..2P-1
    t_load             tr_ld [1:2*P-1];
    logic              tr_v  [1:2*P-1];
    logic [IW-1:0]     tr_ix [1:2*P-1];

    // handshake
    assign out_load      = !r_out_valid || m_axis_tready;
    assign adv           = r_in_valid && out_load;
    assign s_axis_tready = !r_in_valid || adv;
    assign o_cfg_ready   = 1'b1;

    // server count after this cycle's config write
    assign n_count = (i_cfg_valid && o_cfg_ready) ? i_cfg_data : r_count;

    // active server count, clamped to 1..MAX_SERVERS
    always_comb begin
        if (n_count == '0) begin
            n_active = AW'(1);
        end else if (int'(n_count) > MAX_SERVERS) begin
            n_active = AW'(MAX_SERVERS);
        end else begin
            n_active = AW'(n_count);
        end
    end

    // saturating add on the least-loaded server
    assign old_load = r_loads[r_best];
    assign wide_sum = {1'b0, old_load} + {{(LOAD_W + 1 - DUR_W){1'b0}}, r_in_dur};
    assign new_load = wide_sum[LOAD_W] ? {LOAD_W{1'b1}} : wide_sum[LOAD_W-1:0];
    assign new_sat  = (new_load == {LOAD_W{1'b1}});

    // next load set
    always_comb begin
        for (int i = 0; i < MAX_SERVERS; i++) begin
            n_loads[i] = r_loads[i];
            if (adv) begin
                if (r_in_mode == MODE_CLEAR) begin
                    n_loads[i] = '0;
                end else if (IW'(i) == r_best) begin
                    n_loads[i] = new_load;
                end
            end
        end
    end

    // argmin tree over active servers, left wins ties
    always_comb begin
        for (int i = 0; i < P; i++) begin
            tr_ld[P + i] = '0;
            tr_v[P + i]  = 1'b0;
            tr_ix[P + i] = IW'(i);
        end
        for (int i = 0; i < MAX_SERVERS; i++) begin
            tr_ld[P + i] = n_loads[i];
            tr_v[P + i]  = (i < int'(n_active));
        end
        for (int k = P - 1; k >= 1; k--) begin
            if (tr_v[2*k] && (!tr_v[2*k+1] || tr_ld[2*k] <= tr_ld[2*k+1])) begin
                tr_ld[k] = tr_ld[2*k];
                tr_v[k]  = 1'b1;
                tr_ix[k] = tr_ix[2*k];
            end else begin
                tr_ld[k] = tr_ld[2*k+1];
                tr_v[k]  = tr_v[2*k+1];
                tr_ix[k] = tr_ix[2*k+1];
            end
        end
        n_best = tr_ix[1];
    end

    // control and load registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_count     <= CNT_W'(1);
            r_best      <= '0;
            for (int i = 0; i < MAX_SERVERS; i++) begin
                r_loads[i] <= '0;
            end
        end else begin
            if (s_axis_tready) begin
                r_in_valid <= s_axis_tvalid;
            end
            if (out_load) begin
                r_out_valid <= r_in_valid;
            end
            r_count <= n_count;
            r_best  <= n_best;
            for (int i = 0; i < MAX_SERVERS; i++) begin
                r_loads[i] <= n_loads[i];
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (s_axis_tready && s_axis_tvalid) begin
            r_in_mode <= s_axis_tuser;
            r_in_dur  <= s_axis_tdata;
        end
        if (adv) begin
            r_out_next <= SRV_W'(int'(n_best) + 1);
            if (r_in_mode == MODE_CLEAR) begin
                r_out_assigned <= '0;
                r_out_sat      <= 1'b0;
            end else begin
                r_out_assigned <= SRV_W'(int'(r_best) + 1);
                r_out_sat      <= new_sat;
            end
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {{(OUT_DATA_W - OUT_FIELD_W){1'b0}},
                            r_out_sat, r_out_next, r_out_assigned};

`ifndef SYNTH
    // the tracked least-loaded server index always stays below MAX_SERVERS
    a_best_active: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        int'(r_best) < MAX_SERVERS)
        else $error("least-loaded server index out of range");

    // a clear leaves the chosen server at zero load
    a_clear_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (adv && r_in_mode == MODE_CLEAR) |=> (r_loads[r_best] == '0))
        else $error("load not zero after clear");

    // an assigned job never lowers the server's load
    a_load_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (adv && r_in_mode == MODE_ASSIGN) |=>
            (r_loads[$past(r_best)] >= $past(old_load)))
        else $error("server load decreased on assign");

    // a result enters the output register only when a request advances
    a_out_from_adv: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!r_out_valid && !r_in_valid) |=> !r_out_valid)
        else $error("result without request");
`endif

endmodule
